// ===== design/ems_pkg.sv =====
// shared types and constants for the eased marker slide block
package ems_pkg;

    localparam int POS_W    = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int ROWH_W   = 8;
    localparam int HEIGHT_W = 15;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // request codes
    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_DURATION = 2'd0;
    localparam logic [1:0] REG_STEP     = 2'd1;
    localparam logic [1:0] REG_ROW_H    = 2'd2;

    localparam logic [CFG_W-1:0]  DURATION_RST = 16'd200;
    localparam logic [CFG_W-1:0]  STEP_RST     = 16'd16;
    localparam logic [ROWH_W-1:0] ROW_H_RST    = 8'd16;

    // progress is in units of 1/1024
    localparam int QUO_BITS   = 10;
    localparam int EASE_W     = QUO_BITS + 1;
    localparam int CUBE_SHIFT = 2 * QUO_BITS;
    localparam logic [EASE_W-1:0] EASE_ONE = 11'd1024;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 15'h7fff;

    typedef struct packed {
        logic                done;
        logic [QUO_BITS-1:0] quo;
    } t_div_sts;

endpackage

// ===== design/ems_intf.sv =====
// request and result channel interfaces
interface ems_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       req_type;
    logic signed [ems_pkg::POS_W-1:0] position;
    logic signed [ems_pkg::POS_W-1:0] target;
    logic [ems_pkg::TIME_W-1:0]       time_now;

    modport source (output valid, output req_type, output position, output target,
                    output time_now, input ready);
    modport sink   (input valid, input req_type, input position, input target,
                    input time_now, output ready);
endinterface

interface ems_res_if;
    logic                                valid;
    logic                                ready;
    logic                                repaint;
    logic signed [ems_pkg::POS_W-1:0]    dirty_top;
    logic [ems_pkg::HEIGHT_W-1:0]        dirty_height;
    logic signed [ems_pkg::POS_W-1:0]    marker_y;
    logic                                busy_res;

    modport source (output valid, output repaint, output dirty_top, output dirty_height,
                    output marker_y, output busy_res, input ready);
    modport sink   (input valid, input repaint, input dirty_top, input dirty_height,
                    input marker_y, input busy_res, output ready);
endinterface

// ===== design/ems_div.sv =====
// radix-2 restoring divider for the progress fraction, one quotient bit a cycle
module ems_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ems_pkg::CFG_W-1:0]    i_rem,
    input  logic [ems_pkg::CFG_W-1:0]    i_divisor,
    output ems_pkg::t_div_sts            o_sts
);

    localparam int CNT_W = $clog2(ems_pkg::QUO_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ems_pkg::QUO_BITS - 1);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [ems_pkg::CFG_W-1:0]    r_rem;
    logic [ems_pkg::CFG_W-1:0]    r_div;
    logic [ems_pkg::QUO_BITS-1:0] r_quo;

    logic [ems_pkg::CFG_W:0]      shifted;
    logic [ems_pkg::CFG_W:0]      trial;
    logic                         fits;

    // remainder stays below the divisor, so a 17-bit trial is enough
    assign shifted = {r_rem, 1'b0};
    assign trial   = shifted - {1'b0, r_div};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? trial[ems_pkg::CFG_W-1:0] : shifted[ems_pkg::CFG_W-1:0];
            r_quo <= {r_quo[ems_pkg::QUO_BITS-2:0], fits};
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.quo  = r_quo;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted mid-division");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("divider remainder reached divisor");

endmodule

// ===== design/eased_marker_slide_core.sv =====
// top level of the eased marker slide block: sequencer, shared multiplier, state, apb
//
// usage:
//   i_req carries one request (init, start or tick) per valid/ready handshake.
//   o_res returns exactly one result for every request, in order.
//   the apb port writes anim_duration (0x0), step_interval (0x4) and
//   row_height (0x8); reads return the register value, pready is tied high.
// request flow:
//   init, start, unknown codes and ticks that do not move the slide along
//   the curve go from acceptance through S_FIN into the output register.
//   a tick that lands inside the slide runs the 10-bit progress divider
//   (one quotient bit per cycle), then three passes through the one shared
//   multiplier (square, cube, distance) and a rounding add, then S_FIN and
//   the output register. i_req.ready is high only while the sequencer is idle
//   and out of reset, so one request is in flight.
// reset (synchronous, active low): slide stopped, all positions and times
//   zero, registers at 200 / 16 / 16, no result pending.
// stall: a finished result sits in the output register; the next request
//   is still accepted, but its result waits until o_res is taken.
module eased_marker_slide_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ems_req_if.sink                           i_req,
    ems_res_if.source                         o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ems_pkg::ADDR_W-1:0]        paddr,
    input  logic [ems_pkg::DATA_W-1:0]        pwdata,
    output logic [ems_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SQ,
        S_CUBE,
        S_DIST,
        S_ADD,
        S_FIN
    } t_state;

    localparam int PW = ems_pkg::POS_W;
    localparam int EW = ems_pkg::EASE_W;

    // configuration
    logic [ems_pkg::CFG_W-1:0]  r_dur;
    logic [ems_pkg::CFG_W-1:0]  r_step;
    logic [ems_pkg::ROWH_W-1:0] r_row_h;

    // slide state
    logic                       r_running;
    logic signed [PW-1:0]       r_origin;
    logic signed [PW-1:0]       r_goal;
    logic signed [PW-1:0]       r_now_y;
    logic signed [PW-1:0]       r_prior;
    logic [ems_pkg::TIME_W-1:0] r_begin;
    logic [ems_pkg::TIME_W-1:0] r_last;

    // sequencer and latched request
    t_state                     r_state, n_state;
    logic [1:0]                 r_req;
    logic signed [PW-1:0]       r_pos;
    logic signed [PW-1:0]       r_tgt;
    logic [ems_pkg::TIME_W-1:0] r_time;
    logic                       r_due;
    logic                       r_snap;
    logic [EW-1:0]              r_inv;
    logic signed [33:0]         r_prod;
    logic signed [PW-1:0]       r_next;

    // output register
    logic                       r_out_valid;
    logic                       r_out_repaint;
    logic signed [PW-1:0]       r_out_top;
    logic [ems_pkg::HEIGHT_W-1:0] r_out_height;
    logic signed [PW-1:0]       r_out_y;
    logic                       r_out_busy;

    logic                       accept;
    logic                       fin_go;
    logic                       cfg_wr;
    logic [ems_pkg::TIME_W-1:0] since_upd;
    logic [ems_pkg::TIME_W-1:0] elapsed;
    logic                       due;
    logic                       snap;
    logic                       div_start;
    ems_pkg::t_div_sts          div_sts;

    logic [EW-1:0]              inv;
    logic [EW-1:0]              eased;
    logic signed [PW:0]         travel;
    logic signed [21:0]         mul_a;
    logic signed [11:0]         mul_b;
    logic signed [33:0]         mul_p;
    logic signed [33:0]         rnd;
    logic signed [33:0]         quot;
    logic signed [PW:0]         next_sum;

    logic signed [PW-1:0]       start_y;
    logic                       moved;
    logic signed [PW-1:0]       lo;
    logic signed [PW-1:0]       hi;
    logic [PW:0]                span;
    logic [PW:0]                hsum;
    logic [ems_pkg::HEIGHT_W-1:0] height;
    logic                       fin_running;
    logic signed [PW-1:0]       fin_y;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            ems_pkg::REG_DURATION: prdata = {16'd0, r_dur};
            ems_pkg::REG_STEP:     prdata = {16'd0, r_step};
            ems_pkg::REG_ROW_H:    prdata = {24'd0, r_row_h};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur   <= ems_pkg::DURATION_RST;
            r_step  <= ems_pkg::STEP_RST;
            r_row_h <= ems_pkg::ROW_H_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                ems_pkg::REG_DURATION: r_dur   <= pwdata[ems_pkg::CFG_W-1:0];
                ems_pkg::REG_STEP:     r_step  <= pwdata[ems_pkg::CFG_W-1:0];
                ems_pkg::REG_ROW_H:    r_row_h <= pwdata[ems_pkg::ROWH_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- request intake ----------------
    // no request is taken while reset is held
    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    // time differences wrap modulo 2^32
    assign since_upd = i_req.time_now - r_last;
    assign elapsed   = i_req.time_now - r_begin;
    assign due       = (i_req.req_type == ems_pkg::REQ_TICK) && r_running &&
                       (since_upd >= {16'd0, r_step});
    // past the duration the marker snaps to the goal, no division
    assign snap      = elapsed >= {16'd0, r_dur};
    assign div_start = accept && due && !snap;

    // elapsed < duration here, so it fits 16 bits and the quotient fits 10
    ems_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_rem     (elapsed[ems_pkg::CFG_W-1:0]),
        .i_divisor (r_dur),
        .o_sts     (div_sts)
    );

    // ---------------- shared multiplier ----------------
    assign inv    = ems_pkg::EASE_ONE - {1'b0, div_sts.quo};
    // eased = 1024 - (inv^3 >> 20)
    assign eased  = ems_pkg::EASE_ONE - r_prod[30:ems_pkg::CUBE_SHIFT];
    assign travel = {r_goal[PW-1], r_goal} - {r_origin[PW-1], r_origin};

    always_comb begin
        case (r_state)
            S_SQ: begin
                mul_a = $signed({11'd0, r_inv});
                mul_b = $signed({1'b0, r_inv});
            end
            S_CUBE: begin
                mul_a = $signed({1'b0, r_prod[20:0]});
                mul_b = $signed({1'b0, r_inv});
            end
            S_DIST: begin
                mul_a = $signed({{5{travel[PW]}}, travel});
                mul_b = $signed({1'b0, eased});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // divide by 1024 truncating toward zero: bias negatives before the shift
    assign rnd      = r_prod + (r_prod[33] ? 34'sd1023 : 34'sd0);
    assign quot     = rnd >>> ems_pkg::QUO_BITS;
    assign next_sum = {r_origin[PW-1], r_origin} + quot[PW:0];

    // ---------------- result of the request ----------------
    assign fin_go  = (r_state == S_FIN) && (!r_out_valid || o_res.ready);
    assign start_y = r_running ? r_now_y : r_pos;
    assign moved   = (r_req == ems_pkg::REQ_TICK) && r_due && (r_next != r_now_y);
    assign lo      = (r_now_y < r_next) ? r_now_y : r_next;
    assign hi      = (r_now_y < r_next) ? r_next : r_now_y;
    assign span    = {hi[PW-1], hi} - {lo[PW-1], lo};
    assign hsum    = {1'b0, span[PW-1:0]} + {9'd0, r_row_h};
    assign height  = (hsum > {2'b00, ems_pkg::HEIGHT_MAX}) ? ems_pkg::HEIGHT_MAX
                                                          : hsum[ems_pkg::HEIGHT_W-1:0];

    always_comb begin
        fin_running = r_running;
        fin_y       = r_now_y;
        case (r_req)
            ems_pkg::REQ_INIT: begin
                fin_running = 1'b0;
                fin_y       = r_pos;
            end
            ems_pkg::REQ_START: begin
                fin_running = (start_y != r_tgt);
                fin_y       = start_y;
            end
            ems_pkg::REQ_TICK: begin
                if (r_due && r_snap) begin
                    fin_running = 1'b0;
                end
                if (moved) begin
                    fin_y = r_next;
                end
            end
            default: ;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = div_start ? S_DIV : S_FIN;
            S_DIV:   if (div_sts.done) n_state = S_SQ;
            S_SQ:    n_state = S_CUBE;
            S_CUBE:  n_state = S_DIST;
            S_DIST:  n_state = S_ADD;
            S_ADD:   n_state = S_FIN;
            S_FIN:   if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_running   <= 1'b0;
            r_origin    <= '0;
            r_goal      <= '0;
            r_now_y     <= '0;
            r_prior     <= '0;
            r_begin     <= '0;
            r_last      <= '0;
        end else begin
            r_state <= n_state;

            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            if (fin_go) begin
                r_running <= fin_running;
                r_now_y   <= fin_y;
                case (r_req)
                    ems_pkg::REQ_INIT: begin
                        r_origin <= r_pos;
                        r_goal   <= r_pos;
                        r_prior  <= r_pos;
                        r_begin  <= '0;
                        r_last   <= '0;
                    end
                    ems_pkg::REQ_START: begin
                        r_origin <= start_y;
                        r_goal   <= r_tgt;
                        r_prior  <= start_y;
                        r_begin  <= r_time;
                        r_last   <= r_time;
                    end
                    ems_pkg::REQ_TICK: begin
                        if (r_due) begin
                            r_last <= r_time;
                        end
                        if (moved) begin
                            r_prior <= r_now_y;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req.req_type;
            r_pos  <= i_req.position;
            r_tgt  <= i_req.target;
            r_time <= i_req.time_now;
            r_due  <= due;
            r_snap <= snap;
            r_next <= r_goal;
        end
        if (r_state == S_DIV && div_sts.done) begin
            r_inv <= inv;
        end
        if (r_state == S_SQ || r_state == S_CUBE || r_state == S_DIST) begin
            r_prod <= mul_p;
        end
        if (r_state == S_ADD) begin
            r_next <= next_sum[PW-1:0];
        end
        if (fin_go) begin
            r_out_repaint <= moved;
            r_out_top     <= moved ? lo : '0;
            r_out_height  <= moved ? height : '0;
            r_out_y       <= fin_y;
            r_out_busy    <= fin_running;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.repaint      = r_out_repaint;
    assign o_res.dirty_top    = r_out_top;
    assign o_res.dirty_height = r_out_height;
    assign o_res.marker_y     = r_out_y;
    assign o_res.busy_res     = r_out_busy;

    // a running slide always has somewhere to go
    a_run_has_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_origin != r_goal))
        else $error("slide running with origin equal to goal");

    // the marker never leaves the segment between origin and goal
    a_marker_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (((r_now_y >= r_origin) && (r_now_y <= r_goal)) ||
                       ((r_now_y <= r_origin) && (r_now_y >= r_goal))))
        else $error("marker outside slide span");

    // the previous marker position stays on the same segment
    a_prior_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (((r_prior >= r_origin) && (r_prior <= r_goal)) ||
                       ((r_prior <= r_origin) && (r_prior >= r_goal))))
        else $error("previous marker position outside slide span");

    // a tick is only acted on while a slide is running
    a_due_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_due) |-> r_running)
        else $error("tick acted on with no slide running");

    // a tick past the duration ends the slide
    a_snap_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && r_req == ems_pkg::REQ_TICK && r_due && r_snap) |=> !r_running)
        else $error("slide still running after final tick");

endmodule

// ===== tb/sv/eased_marker_slide_core_tb.sv =====
// self-checking testbench for the eased marker slide core: directed table, then random slides
module eased_marker_slide_core_tb;

    // request code the block ignores (still answered with one result)
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [ems_pkg::POS_W-1:0] POS_MIN = 16'sh8000;
    localparam logic signed [ems_pkg::POS_W-1:0] POS_MAX = 16'sh7fff;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 172;
    localparam int NUM_PHASES    = 8;
    localparam int SETTLE_CYCLES = 40;

    // one result of the block, as the receiver sees it
    typedef struct packed {
        logic                                repaint;
        logic signed [ems_pkg::POS_W-1:0]    top;
        logic [ems_pkg::HEIGHT_W-1:0]        height;
        logic signed [ems_pkg::POS_W-1:0]    y;
        logic                                busy;
    } t_marker_update;

    // one row of the directed table; typed rows carry their own answer
    typedef struct packed {
        logic [1:0]                          kind;
        logic signed [ems_pkg::POS_W-1:0]    pos;
        logic signed [ems_pkg::POS_W-1:0]    tgt;
        logic [ems_pkg::TIME_W-1:0]          tnow;
        logic                                typed;
        t_marker_update                      want;
    } t_slide_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // apb side
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ems_pkg::ADDR_W-1:0] paddr;
    logic [ems_pkg::DATA_W-1:0] pwdata;
    logic [ems_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    ems_req_if req_bus ();
    ems_res_if res_bus ();

    // receiver ready comes from a plain variable so it is known from time zero
    logic sink_ready = 1'b0;
    assign res_bus.ready = sink_ready;

    // predictor copy of the block state, reset values in the declarations
    logic                       slide_on = 1'b0;
    int                         org_y    = 0;
    int                         dst_y    = 0;
    int                         cur_y    = 0;
    int                         old_y    = 0;
    logic [ems_pkg::TIME_W-1:0] t_begin  = '0;
    logic [ems_pkg::TIME_W-1:0] t_last   = '0;

    // predictor copy of the registers
    logic [ems_pkg::CFG_W-1:0]  cfg_dur  = ems_pkg::DURATION_RST;
    logic [ems_pkg::CFG_W-1:0]  cfg_step = ems_pkg::STEP_RST;
    logic [ems_pkg::ROWH_W-1:0] cfg_rowh = ems_pkg::ROW_H_RST;

    t_marker_update marker_updates_q[$];
    t_slide_row     dir_rows[$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  items_sent  = 0;
    int  sink_hold   = 0;
    // calm stretches: no idling on that side
    logic src_calm  = 1'b0;
    logic sink_calm = 1'b0;

    eased_marker_slide_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    endtask

    // mostly short idles, now and then a long one
    function automatic int idle_len();
        return int'(($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                : $urandom_range(1, 3));
    endfunction

    // predictor: applies one request to the state copy, returns the result it causes
    function automatic t_marker_update slide_marker(
            input logic [1:0] kind,
            input logic signed [ems_pkg::POS_W-1:0] pos,
            input logic signed [ems_pkg::POS_W-1:0] tgt,
            input logic [ems_pkg::TIME_W-1:0] tnow);
        t_marker_update             r;
        int                         start_y, nxt, travel, eased, tq, inv, lo, hi, h;
        logic [ems_pkg::TIME_W-1:0] elapsed, since;
        r       = '0;
        since   = tnow - t_last;
        elapsed = tnow - t_begin;
        case (kind)
            ems_pkg::REQ_INIT: begin
                // place the marker, stop any slide, clear both times
                slide_on = 1'b0;
                org_y    = int'(pos);
                dst_y    = int'(pos);
                cur_y    = int'(pos);
                old_y    = int'(pos);
                t_begin  = '0;
                t_last   = '0;
            end
            ems_pkg::REQ_START: begin
                // a running slide continues from where the marker is now
                start_y  = slide_on ? cur_y : int'(pos);
                slide_on = (start_y != int'(tgt));
                org_y    = start_y;
                dst_y    = int'(tgt);
                cur_y    = start_y;
                old_y    = start_y;
                t_begin  = tnow;
                t_last   = tnow;
            end
            ems_pkg::REQ_TICK: begin
                if (slide_on && since >= {16'd0, cfg_step}) begin
                    if (elapsed >= {16'd0, cfg_dur}) begin
                        eased = 1024;
                    end else begin
                        // progress in 1/1024, then ease-out cube
                        tq    = int'((elapsed * 32'd1024) / {16'd0, cfg_dur});
                        inv   = 1024 - tq;
                        eased = 1024 - ((inv * inv * inv) >> 20);
                    end
                    // signed division truncates toward zero
                    travel = dst_y - org_y;
                    nxt    = org_y + (travel * eased) / 1024;
                    if (elapsed >= {16'd0, cfg_dur}) begin
                        nxt      = dst_y;
                        slide_on = 1'b0;
                    end
                    t_last = tnow;
                    if (nxt != cur_y) begin
                        old_y = cur_y;
                        cur_y = nxt;
                        lo    = (old_y < cur_y) ? old_y : cur_y;
                        hi    = (old_y > cur_y) ? old_y : cur_y;
                        h     = hi - lo + int'(cfg_rowh);
                        if (h > 32767)
                            h = 32767;
                        r.repaint = 1'b1;
                        r.top     = lo[ems_pkg::POS_W-1:0];
                        r.height  = h[ems_pkg::HEIGHT_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        r.y    = cur_y[ems_pkg::POS_W-1:0];
        r.busy = slide_on;
        return r;
    endfunction

    function automatic t_slide_row mk_row(input logic [1:0] kind, input int pos, input int tgt,
                                          input logic [ems_pkg::TIME_W-1:0] tnow,
                                          input logic typed, input logic rp, input int top,
                                          input int ht, input int y, input logic busy);
        t_slide_row r;
        r.kind         = kind;
        r.pos          = pos[ems_pkg::POS_W-1:0];
        r.tgt          = tgt[ems_pkg::POS_W-1:0];
        r.tnow         = tnow;
        r.typed        = typed;
        r.want.repaint = rp;
        r.want.top     = top[ems_pkg::POS_W-1:0];
        r.want.height  = ht[ems_pkg::HEIGHT_W-1:0];
        r.want.y       = y[ems_pkg::POS_W-1:0];
        r.want.busy    = busy;
        return r;
    endfunction

    // positions: extremes, small values near zero, or anything
    function automatic logic signed [ems_pkg::POS_W-1:0] pick_pos();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return POS_MIN;
            1:       return POS_MAX;
            2:       return ems_pkg::POS_W'(int'(r[5:0]) - 32);
            default: return r[ems_pkg::POS_W-1:0];
        endcase
    endfunction

    // time step between ticks: mostly due, sometimes early, rarely wild
    function automatic logic [ems_pkg::TIME_W-1:0] tick_gap();
        int unsigned s, span;
        s    = {16'd0, cfg_step};
        span = {16'd0, cfg_dur} / 32'd5 + 32'd1;
        case ($urandom_range(0, 15))
            0:          return '0;
            1:          return $urandom;
            2, 3, 4:    return $urandom_range(0, s);
            default:    return $urandom_range(s, s + span);
        endcase
    endfunction

    // offer one request, wait for the handshake, queue what it should produce
    task automatic send_req(input logic [1:0] kind,
                            input logic signed [ems_pkg::POS_W-1:0] pos,
                            input logic signed [ems_pkg::POS_W-1:0] tgt,
                            input logic [ems_pkg::TIME_W-1:0] tnow,
                            input logic typed, input t_marker_update want);
        int             gap;
        t_marker_update pred;
        gap = (!src_calm && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if ($urandom_range(0, 99) == 0)
            src_calm = !src_calm;
        if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.position <= pos;
        req_bus.target   <= tgt;
        req_bus.time_now <= tnow;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        pred = slide_marker(kind, pos, tgt, tnow);
        // typed rows keep their own answer, the state still moves on
        marker_updates_q.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // stop offering and wait until every outstanding result is back
    task automatic drain_marker_updates();
        req_bus.valid <= 1'b0;
        while (marker_updates_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write of one register, then read it back
    task automatic write_register(input logic [1:0] idx, input logic [ems_pkg::CFG_W-1:0] val);
        logic [ems_pkg::DATA_W-1:0] back, want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ems_pkg::REG_DURATION: cfg_dur  = val;
            ems_pkg::REG_STEP:     cfg_step = val;
            ems_pkg::REG_ROW_H:    cfg_rowh = val[ems_pkg::ROWH_W-1:0];
            default: ;
        endcase
        want = (idx == ems_pkg::REG_ROW_H) ? {24'd0, val[ems_pkg::ROWH_W-1:0]} : {16'd0, val};
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        back = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (back !== want)
            report_mismatch("register readback", int'(back), int'(want));
    endtask

    // random part: mostly whole slides with random content, some noise and broken ones
    task automatic run_slides(input int quota);
        int                               stop_at, pick;
        logic [ems_pkg::TIME_W-1:0]       t;
        logic signed [ems_pkg::POS_W-1:0] p, q;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 15);
            if (pick < 11) begin
                // well-formed slide: optional init, start, a run of ticks
                if ($urandom_range(0, 1))
                    send_req(ems_pkg::REQ_INIT, pick_pos(), pick_pos(), $urandom, 1'b0, '0);
                // some slides start just short of the time wrap
                if ($urandom_range(0, 5) == 0)
                    t = 32'hffff_ffff - $urandom_range(0, 32'd2 * {16'd0, cfg_dur});
                else
                    t = $urandom;
                p = pick_pos();
                q = ($urandom_range(0, 9) == 0) ? p : pick_pos();
                send_req(ems_pkg::REQ_START, p, q, t, 1'b0, '0);
                repeat ($urandom_range(3, 14)) begin
                    t = t + tick_gap();
                    // now and then retarget in the middle of a slide
                    if ($urandom_range(0, 11) == 0)
                        send_req(ems_pkg::REQ_START, pick_pos(), pick_pos(), t, 1'b0, '0);
                    else
                        send_req(ems_pkg::REQ_TICK, pick_pos(), pick_pos(), t, 1'b0, '0);
                end
            end else if (pick < 13) begin
                // noise: any code, any fields
                repeat ($urandom_range(1, 4))
                    send_req(2'($urandom_range(0, 3)), pick_pos(), pick_pos(), $urandom,
                             1'b0, '0);
            end else begin
                // broken slide: ticks right at the step and duration boundaries
                t = $urandom;
                send_req(ems_pkg::REQ_START, pick_pos(), pick_pos(), t, 1'b0, '0);
                send_req(ems_pkg::REQ_TICK, pick_pos(), pick_pos(),
                         t + {16'd0, cfg_step} - 32'd1, 1'b0, '0);
                send_req(ems_pkg::REQ_TICK, pick_pos(), pick_pos(),
                         t + {16'd0, cfg_step}, 1'b0, '0);
                send_req(ems_pkg::REQ_TICK, pick_pos(), pick_pos(),
                         t + {16'd0, cfg_dur}, 1'b0, '0);
                case ($urandom_range(0, 2))
                    0: begin
                        // time runs backwards
                        send_req(ems_pkg::REQ_TICK, pick_pos(), pick_pos(),
                                 t - $urandom_range(1, 5000), 1'b0, '0);
                    end
                    1: begin
                        // init cuts the slide, the following tick finds it idle
                        send_req(ems_pkg::REQ_INIT, pick_pos(), pick_pos(), $urandom,
                                 1'b0, '0);
                        send_req(ems_pkg::REQ_TICK, pick_pos(), pick_pos(),
                                 t + {16'd0, cfg_dur}, 1'b0, '0);
                    end
                    default: begin
                        send_req(ems_pkg::REQ_START, pick_pos(), pick_pos(), t + 32'd1,
                                 1'b0, '0);
                        send_req(ems_pkg::REQ_TICK, pick_pos(), pick_pos(), $urandom,
                                 1'b0, '0);
                    end
                endcase
            end
        end
    endtask

    // receiver: compare each taken result with the oldest prediction, stall at random
    always @(posedge i_clk) begin : result_side
        t_marker_update got, want;
        if (res_bus.valid && sink_ready) begin
            got.repaint = res_bus.repaint;
            got.top     = res_bus.dirty_top;
            got.height  = res_bus.dirty_height;
            got.y       = res_bus.marker_y;
            got.busy    = res_bus.busy_res;
            if (marker_updates_q.size() == 0) begin
                report_mismatch("result with no request outstanding", int'(got.y), 0);
            end else begin
                want = marker_updates_q.pop_front();
                if (got.repaint !== want.repaint)
                    report_mismatch("repaint", int'(got.repaint), int'(want.repaint));
                if (got.top !== want.top)
                    report_mismatch("dirty_top", int'(got.top), int'(want.top));
                if (got.height !== want.height)
                    report_mismatch("dirty_height", int'(got.height), int'(want.height));
                if (got.y !== want.y)
                    report_mismatch("marker_y", int'(got.y), int'(want.y));
                if (got.busy !== want.busy)
                    report_mismatch("busy_res", int'(got.busy), int'(want.busy));
            end
        end
        if (sink_hold != 0) begin
            sink_hold  <= sink_hold - 1;
            sink_ready <= 1'b0;
        end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
            sink_hold  <= idle_len() - 1;
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= 1'b1;
        end
        if ($urandom_range(0, 149) == 0)
            sink_calm <= !sink_calm;
    end

    initial begin
        int                         ph;
        logic [ems_pkg::CFG_W-1:0]  dur_v, step_v;
        logic [ems_pkg::ROWH_W-1:0] rowh_v;

        i_rst_n          <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= ems_pkg::REQ_INIT;
        req_bus.position <= '0;
        req_bus.target   <= '0;
        req_bus.time_now <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;

        // directed table, registers at reset values (200 / 16 / 16)
        // tick after reset with nothing running
        dir_rows.push_back(mk_row(ems_pkg::REQ_TICK, 0, 0, 32'd100,
                                  1'b1, 1'b0, 0, 0, 0, 1'b0));
        // unused code with every field bit set
        dir_rows.push_back(mk_row(REQ_UNUSED, -1, -1, 32'hffff_ffff,
                                  1'b1, 1'b0, 0, 0, 0, 1'b0));
        // init at both extremes
        dir_rows.push_back(mk_row(ems_pkg::REQ_INIT, 32767, 0, 32'd0,
                                  1'b1, 1'b0, 0, 0, 32767, 1'b0));
        dir_rows.push_back(mk_row(ems_pkg::REQ_INIT, -32768, -32768, 32'hffff_ffff,
                                  1'b1, 1'b0, 0, 0, -32768, 1'b0));
        // start onto the same spot: loaded but not running
        dir_rows.push_back(mk_row(ems_pkg::REQ_START, 5, 5, 32'd1000,
                                  1'b1, 1'b0, 0, 0, 5, 1'b0));
        dir_rows.push_back(mk_row(ems_pkg::REQ_TICK, 0, 0, 32'd2000,
                                  1'b1, 1'b0, 0, 0, 5, 1'b0));
        // full-range slide upward
        dir_rows.push_back(mk_row(ems_pkg::REQ_START, -32768, 32767, 32'd1000,
                                  1'b1, 1'b0, 0, 0, -32768, 1'b1));
        // tick before the step interval has passed
        dir_rows.push_back(mk_row(ems_pkg::REQ_TICK, 0, 0, 32'd1010,
                                  1'b1, 1'b0, 0, 0, -32768, 1'b1));
        dir_rows.push_back(mk_row(ems_pkg::REQ_TICK, 0, 0, 32'd1016,
                                  1'b0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(mk_row(ems_pkg::REQ_TICK, 0, 0, 32'd1100,
                                  1'b0, 1'b0, 0, 0, 0, 1'b0));
        // retarget while running: starts from the current marker, not the field
        dir_rows.push_back(mk_row(ems_pkg::REQ_START, 12345, 0, 32'd1150,
                                  1'b0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(mk_row(ems_pkg::REQ_TICK, 0, 0, 32'd1160,
                                  1'b0, 1'b0, 0, 0, 0, 1'b0));
        // past the duration: snap to target
        dir_rows.push_back(mk_row(ems_pkg::REQ_TICK, 0, 0, 32'd1400,
                                  1'b0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(mk_row(ems_pkg::REQ_TICK, 0, 0, 32'd1500,
                                  1'b1, 1'b0, 0, 0, 0, 1'b0));
        // slide across the time wrap, snap gives a saturated band
        dir_rows.push_back(mk_row(ems_pkg::REQ_INIT, 0, 0, 32'd0,
                                  1'b1, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(mk_row(ems_pkg::REQ_START, 0, -32768, 32'hffff_fff0,
                                  1'b1, 1'b0, 0, 0, 0, 1'b1));
        dir_rows.push_back(mk_row(ems_pkg::REQ_TICK, 0, 0, 32'h0000_0100,
                                  1'b1, 1'b1, -32768, 32767, -32768, 1'b0));
        // idle start uses the given position, here equal to the target
        dir_rows.push_back(mk_row(ems_pkg::REQ_START, 32767, 32767, 32'd5000,
                                  1'b1, 1'b0, 0, 0, 32767, 1'b0));
        dir_rows.push_back(mk_row(ems_pkg::REQ_START, 0, -32768, 32'd6000,
                                  1'b1, 1'b0, 0, 0, 0, 1'b1));
        dir_rows.push_back(mk_row(ems_pkg::REQ_TICK, 0, 0, 32'd6016,
                                  1'b0, 1'b0, 0, 0, 0, 1'b0));
        // time going backwards: huge difference, snap
        dir_rows.push_back(mk_row(ems_pkg::REQ_TICK, 0, 0, 32'd3000,
                                  1'b0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(mk_row(REQ_UNUSED, 100, 200, 32'd7000,
                                  1'b1, 1'b0, 0, 0, -32768, 1'b0));
        dir_rows.push_back(mk_row(ems_pkg::REQ_TICK, 32767, -1, 32'hffff_ffff,
                                  1'b1, 1'b0, 0, 0, -32768, 1'b0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].kind, dir_rows[i].pos, dir_rows[i].tgt, dir_rows[i].tnow,
                     dir_rows[i].typed, dir_rows[i].want);

        // random phases, each under its own register setting
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    dur_v = 16'd1;     step_v = 16'd0;     rowh_v = 8'd1;
                end
                1: begin
                    dur_v = 16'd65535; step_v = 16'd65535; rowh_v = 8'd255;
                end
                2: begin
                    dur_v = 16'd64;    step_v = 16'd1;     rowh_v = 8'd16;
                end
                3: begin
                    dur_v = 16'd300;   step_v = 16'd0;     rowh_v = 8'd200;
                end
                4: begin
                    dur_v = 16'd65535; step_v = 16'd0;     rowh_v = 8'd1;
                end
                default: begin
                    dur_v  = 16'($urandom_range(1, 3000));
                    step_v = 16'($urandom_range(0, 60));
                    rowh_v = 8'($urandom_range(1, 255));
                end
            endcase
            // registers change only with nothing in flight
            drain_marker_updates();
            write_register(ems_pkg::REG_DURATION, dur_v);
            write_register(ems_pkg::REG_STEP, step_v);
            write_register(ems_pkg::REG_ROW_H, {8'd0, rowh_v});
            run_slides(PHASE_ITEMS);
        end

        drain_marker_updates();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
